@@ rtl/scle_pkg.sv @@
package scle_pkg;

  // Item kinds
  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_LEN_TICK = 2'd1;
  localparam logic [1:0] KIND_ENV_TICK = 2'd2;

  // Register selects
  localparam logic [1:0] REG_DUTY_LEN = 2'd0;
  localparam logic [1:0] REG_ENVELOPE = 2'd1;
  localparam logic [1:0] REG_FREQ_LO  = 2'd2;
  localparam logic [1:0] REG_FREQ_HI  = 2'd3;

  localparam int unsigned LenCountW = 7;
  localparam logic [LenCountW-1:0] LenFull = 7'd64;
  localparam logic [3:0] EnvTimerDefault = 4'd8;
  localparam logic [3:0] LevelMax = 4'd15;

endpackage

@@ rtl/square_channel_length_envelope_top.sv @@
// Square-wave channel control: length counter, volume envelope and the
// frequency/duty latches of a sound chip voice.
//
// Input channel (in_valid_i/in_ready_o) carries one transaction per
// register write, length tick or envelope tick: kind_i selects which,
// reg_sel_i and data_i are used by writes only. Output channel
// (out_valid_o/out_ready_i) returns exactly one transaction per input:
// the channel state after that input took effect.
//
// The input register takes the transaction; once the result slot is
// free, the channel state registers, which double as the result
// register, take the update. Throughput is one transaction per cycle
// while the receiver does not stall; the update is a few small counters
// and compares between those two register stages.
//
// Reset clears all state (length count loads 64) and empties both stages.
// When the receiver stalls, the result and the channel state hold; the
// input register still fills, so one more transaction is taken before
// in_ready_o drops.
module square_channel_length_envelope_top
  import scle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  reg_sel_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        enabled_o,
  output logic [3:0]  volume_o,
  output logic [10:0] frequency_o,
  output logic [1:0]  duty_code_o
);

  // Input stage
  logic       s1_valid_q;
  logic [1:0] s1_kind_q;
  logic [1:0] s1_sel_q;
  logic [7:0] s1_data_q;
  logic       out_valid_q;
  logic       advance;

  // Advance the input stage into the state when the result slot frees up.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture on every accepted transaction, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_kind_q <= kind_i;
      s1_sel_q  <= reg_sel_i;
      s1_data_q <= data_i;
    end
  end

  // Channel state
  logic                 channel_on_q, channel_on_d;
  logic [3:0]           level_q, level_d;
  logic [10:0]          period_q, period_d;
  logic [1:0]           duty_q, duty_d;
  logic [LenCountW-1:0] len_count_q, len_count_d;
  logic                 len_on_q, len_on_d;
  logic [3:0]           env_timer_q, env_timer_d;
  logic                 env_on_q, env_on_d;
  logic [7:0]           env_set_q, env_set_d;
  logic [5:0]           len_set_q, len_set_d;

  logic                 trigger;
  logic [2:0]           env_period;
  logic [3:0]           env_reload;
  logic [3:0]           timer_dec;

  assign trigger    = (s1_kind_q == KIND_WRITE) && (s1_sel_q == REG_FREQ_HI) && s1_data_q[7];
  assign env_period = env_set_q[2:0];
  assign env_reload = (env_period != 3'd0) ? {1'b0, env_period} : EnvTimerDefault;
  assign timer_dec  = env_timer_q - 4'd1;

  always_comb begin
    channel_on_d = channel_on_q;
    level_d      = level_q;
    period_d     = period_q;
    duty_d       = duty_q;
    len_count_d  = len_count_q;
    len_on_d     = len_on_q;
    env_timer_d  = env_timer_q;
    env_on_d     = env_on_q;
    env_set_d    = env_set_q;
    len_set_d    = len_set_q;
    unique case (s1_kind_q)
      KIND_WRITE: begin
        unique case (s1_sel_q)
          REG_DUTY_LEN: begin
            duty_d      = s1_data_q[7:6];
            len_set_d   = s1_data_q[5:0];
            len_count_d = LenFull - {1'b0, s1_data_q[5:0]};
          end
          REG_ENVELOPE: begin
            env_set_d = s1_data_q;
          end
          REG_FREQ_LO: begin
            period_d[7:0] = s1_data_q;
          end
          REG_FREQ_HI: begin
            period_d[10:8] = s1_data_q[2:0];
            if (s1_data_q[7]) begin
              // Trigger: restart length and envelope from stored settings.
              len_on_d     = s1_data_q[6];
              channel_on_d = 1'b1;
              env_on_d     = 1'b1;
              level_d      = env_set_q[7:4];
              len_count_d  = LenFull - {1'b0, len_set_q};
              env_timer_d  = env_reload;
            end
          end
          default: ;
        endcase
      end
      KIND_LEN_TICK: begin
        if (len_on_q && (len_count_q != '0)) begin
          len_count_d = len_count_q - LenCountW'(1);
          if (len_count_q == LenCountW'(1)) begin
            channel_on_d = 1'b0;
          end
        end
      end
      KIND_ENV_TICK: begin
        if (env_on_q) begin
          env_timer_d = timer_dec;
          if (timer_dec == 4'd0) begin
            env_timer_d = env_reload;
            if (env_period != 3'd0) begin
              if (env_set_q[3]) begin
                if (level_q < LevelMax) level_d = level_q + 4'd1;
                else                    env_on_d = 1'b0;
              end else begin
                if (level_q != 4'd0) level_d = level_q - 4'd1;
                else                 env_on_d = 1'b0;
              end
            end
          end
        end
      end
      default: ; // unused kind: report state unchanged
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_on_q <= 1'b0;
      level_q      <= '0;
      period_q     <= '0;
      duty_q       <= '0;
      len_count_q  <= LenFull;
      len_on_q     <= 1'b0;
      env_timer_q  <= '0;
      env_on_q     <= 1'b0;
      env_set_q    <= '0;
      len_set_q    <= '0;
    end else if (advance) begin
      channel_on_q <= channel_on_d;
      level_q      <= level_d;
      period_q     <= period_d;
      duty_q       <= duty_d;
      len_count_q  <= len_count_d;
      len_on_q     <= len_on_d;
      env_timer_q  <= env_timer_d;
      env_on_q     <= env_on_d;
      env_set_q    <= env_set_d;
      len_set_q    <= len_set_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign enabled_o   = channel_on_q;
  assign volume_o    = level_q;
  assign frequency_o = period_q;
  assign duty_code_o = duty_q;

  // Length count never exceeds a full reload.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_count_q <= LenFull)
    else $error("length count above full reload");

  // A running envelope always has a nonzero timer.
  a_env_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_on_q |-> (env_timer_q != 4'd0))
    else $error("envelope running with zero timer");

  // The channel only switches on through a trigger.
  a_on_by_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !channel_on_q ##1 channel_on_q |-> $past(advance && trigger))
    else $error("channel enabled without trigger");

  // State changes only when a transaction moves into the result slot.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(level_q) && $stable(len_count_q) && $stable(period_q))
    else $error("channel state changed without a transaction");

  // An empty result slot never blocks the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result slot");

endmodule
